### design/assert_macros.svh
// Assertion macros used by the port checker in odc_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled in reset.
`define ODC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odc assertion failed");
// Next-cycle implication, disabled in reset.
`define ODC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odc assertion failed");
`endif

### design/odc_pkg.sv
// Types, constants and helpers for the motor overcurrent detector.
// No dependencies.
`default_nettype none
package odc_pkg;
  localparam int CUR_W   = 23;
  localparam int DIFF_W  = 24;
  localparam int DET_W   = 17;
  localparam int LVL_W   = 24;
  localparam int CNT_W   = 8;
  localparam int MA_W    = 48;
  localparam int MB_W    = 32;
  localparam int MP_W    = MA_W + MB_W;
  localparam int DN_W    = 32;
  localparam int DD_W    = 9;
  localparam int CFG_W   = 3;

  localparam logic [CUR_W-1:0] CUR_MAX  = '1;
  localparam logic [DET_W-1:0] DET_ONE  = 17'h10000;
  localparam logic [DD_W-1:0]  DIV_FILT = 9'd5;
  localparam logic [DD_W-1:0]  DIV_LVL  = 9'd10;
  // level dividend is biased by 10 * 2^27 so the divider sees a positive value
  localparam logic [DN_W-1:0]  LVL_OFS  = 32'd1342177280;
  localparam logic [DN_W-1:0]  LVL_BIAS = 32'd134217728;
  localparam logic [1:0]       POW_LAST = 2'd2;

  typedef enum logic [CFG_W-1:0] {
    REG_DSQ_L = 3'd0,
    REG_DSQ_R = 3'd1,
    REG_AVG_L = 3'd2,
    REG_AVG_R = 3'd3,
    REG_THR   = 3'd4,
    REG_LIMIT = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILT, ST_DIVF, ST_MEAN, ST_SQ, ST_DSQ,
    ST_POW, ST_ATT, ST_RAT, ST_LVL, ST_DONE
  } state_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [DN_W-1:0] n;
    logic [DD_W-1:0] d;
  } div_req_t;

  function automatic logic [CUR_W-1:0] sample_to_cur(input logic [15:0] s);
    logic [16:0] mag;
    logic [24:0] q;
    mag = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    q   = {mag, 8'h00};
    return (q > {2'b00, CUR_MAX}) ? CUR_MAX : q[CUR_W-1:0];
  endfunction
endpackage
`default_nettype wire

### design/odc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on odc_pkg.
`default_nettype none
module odc_mul (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire odc_pkg::mul_req_t        req,
  output logic                          done,
  output logic [odc_pkg::MP_W-1:0]      prod
);
  localparam int MA_W = odc_pkg::MA_W;
  localparam int MB_W = odc_pkg::MB_W;
  localparam int MP_W = odc_pkg::MP_W;
  localparam int CW   = $clog2(MB_W + 1);

  logic [MP_W-1:0] acc_r;
  logic [MA_W-1:0] mcand_r;
  logic [MB_W-1:0] mplier_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic [MA_W:0]   sum;

  assign sum  = {1'b0, acc_r[MP_W-1:MB_W]} + (mplier_r[0] ? {1'b0, mcand_r} : '0);
  assign done = busy_r && (cnt_r == '0);
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(MB_W);
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r    <= '0;
      mcand_r  <= req.a;
      mplier_r <= req.b;
    end else if (busy_r && cnt_r != '0) begin
      acc_r    <= {sum, acc_r[MB_W-1:1]};
      mplier_r <= {1'b0, mplier_r[MB_W-1:1]};
    end
  end
endmodule
`default_nettype wire

### design/odc_div.sv
// Restoring divider by a small divisor, one quotient bit per cycle.
// Depends on odc_pkg.
`default_nettype none
module odc_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire odc_pkg::div_req_t        req,
  output logic                          done,
  output logic [odc_pkg::DN_W-1:0]      quo
);
  localparam int DN_W = odc_pkg::DN_W;
  localparam int DD_W = odc_pkg::DD_W;
  localparam int CW   = $clog2(DN_W + 1);

  logic [DN_W-1:0] quo_r;
  logic [DD_W-1:0] rem_r;
  logic [DD_W-1:0] d_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic [DD_W:0]   r2;
  logic [DD_W:0]   rdiff;
  logic            ge;

  assign r2    = {rem_r, quo_r[DN_W-1]};
  assign ge    = (r2 >= {1'b0, d_r});
  assign rdiff = r2 - {1'b0, d_r};
  assign done  = busy_r && (cnt_r == '0);
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DN_W);
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.n;
      rem_r <= '0;
      d_r   <= req.d;
    end else if (busy_r && cnt_r != '0) begin
      quo_r <= {quo_r[DN_W-2:0], ge};
      rem_r <= ge ? rdiff[DD_W-1:0] : r2[DD_W-1:0];
    end
  end
endmodule
`default_nettype wire

### design/odc_ring.sv
// Difference ring memory for both motors, with per-entry valid bits.
// Unwritten entries read as zero. No package dependency.
`default_nettype none
module odc_ring #(
  parameter int DEPTH = 32,
  parameter int W     = 48
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [W-1:0]             wdata,
  output logic [W-1:0]                  rdata
);
  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     rd_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[addr];
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;
endmodule
`default_nettype wire

### design/motor_overcurrent_detector.sv
// Motor overcurrent detector top level; uses odc_pkg, odc_mul, odc_div, odc_ring.
// One item at a time: the next beat is taken once the last result is registered, later if
// out stalls. Per motor: filter and ring-mean divides, mean square, detector multiply,
// three more multiplies when the detector is squared, attenuation multiply, level divide,
// on the shared bit-serial multiplier and divider (one bit per cycle). Synchronous
// active-low reset clears control, filter, sum, level, count, config and ring valid bits.
`default_nettype none
module motor_overcurrent_detector #(
  parameter int RING_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_sample_left,
  input  wire logic [15:0] in_sample_right,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_abort,
  output logic [22:0]      out_filtered_left,
  output logic [22:0]      out_filtered_right,
  output logic [15:0]      out_detector_left,
  output logic [15:0]      out_detector_right,
  output logic [7:0]       out_over_count_left,
  output logic [7:0]       out_over_count_right,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int CUR_W  = odc_pkg::CUR_W;
  localparam int DIFF_W = odc_pkg::DIFF_W;
  localparam int DET_W  = odc_pkg::DET_W;
  localparam int LVL_W  = odc_pkg::LVL_W;
  localparam int CNT_W  = odc_pkg::CNT_W;
  localparam int MA_W   = odc_pkg::MA_W;
  localparam int MB_W   = odc_pkg::MB_W;
  localparam int MP_W   = odc_pkg::MP_W;
  localparam int DN_W   = odc_pkg::DN_W;
  localparam int DD_W   = odc_pkg::DD_W;
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int SUM_W  = DIFF_W + PTR_W;

  // configuration registers
  logic [31:0]      dsq_l_r, dsq_r_r;
  logic [23:0]      avg_l_r, avg_r_r;
  logic [15:0]      thr_r;
  logic [CNT_W-1:0] limit_r;

  // sequencer and per-motor state (index 0 left, 1 right)
  odc_pkg::state_t         state_r, state_nxt;
  logic                    mot_r;
  logic [1:0]              pcnt_r;
  logic [PTR_W-1:0]        ptr_r;
  logic [CUR_W-1:0]        cur_r  [2];
  logic signed [DIFF_W-1:0] diff_r [2];
  logic [CUR_W-1:0]        filt_r [2];
  logic signed [SUM_W-1:0] sum_r  [2];
  logic signed [LVL_W-1:0] lvl_r  [2];
  logic [CNT_W-1:0]        cnt_r  [2];
  logic [DET_W-1:0]        det_r  [2];

  // result register
  logic             out_valid_r;
  logic             abort_r;
  logic [CUR_W-1:0] ofl_r, ofr_r;
  logic [15:0]      odl_r, odr_r;
  logic [CNT_W-1:0] ocl_r, ocr_r;

  // shared serial units
  odc_pkg::mul_req_t mul_req;
  odc_pkg::div_req_t div_req;
  logic              mul_done, div_done;
  logic [MP_W-1:0]   mul_prod;
  logic [DN_W-1:0]   div_q;

  logic                     ring_wr;
  logic [2*DIFF_W-1:0]      ring_rd;

  odc_mul u_mul (.clk, .rst_n, .req(mul_req), .done(mul_done), .prod(mul_prod));
  odc_div u_div (.clk, .rst_n, .req(div_req), .done(div_done), .quo(div_q));
  odc_ring #(.DEPTH(RING_DEPTH), .W(2*DIFF_W)) u_ring (
    .clk, .rst_n, .wr_en(ring_wr), .addr(ptr_r),
    .wdata({diff_r[1], diff_r[0]}), .rdata(ring_rd)
  );

  // ---- current motor operands ----
  logic [CUR_W-1:0]         cur_m, filt_m;
  logic signed [SUM_W-1:0]  sum_m;
  logic signed [LVL_W-1:0]  lvl_m;
  logic [CNT_W-1:0]         cnt_m;
  logic [31:0]              dsq_m;
  logic [23:0]              avg_m;
  logic signed [DIFF_W-1:0] ring_old, diff_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic [SUM_W-1:0]         abs_sum;
  logic [DN_W-1:0]          filt_dvd;
  logic                     big;
  logic [15:0]              dsq16, sq16;
  logic [30:0]              ratio;
  logic signed [31:0]       o_c, lvl_s, t_c;
  logic signed [LVL_W-1:0]  lvl_new;
  logic                     ovl;
  logic [CNT_W-1:0]         cnt_new;
  logic                     out_go;

  assign cur_m    = cur_r[mot_r];
  assign filt_m   = filt_r[mot_r];
  assign sum_m    = sum_r[mot_r];
  assign lvl_m    = lvl_r[mot_r];
  assign cnt_m    = cnt_r[mot_r];
  assign dsq_m    = mot_r ? dsq_r_r : dsq_l_r;
  assign avg_m    = mot_r ? avg_r_r : avg_l_r;
  assign ring_old = mot_r ? ring_rd[2*DIFF_W-1:DIFF_W] : ring_rd[DIFF_W-1:0];

  // diff = old filtered - new current; running ring sum
  assign diff_c  = $signed({1'b0, filt_m}) - $signed({1'b0, cur_m});
  assign sum_c   = sum_m + SUM_W'(diff_c) - SUM_W'(ring_old);
  assign abs_sum = sum_m[SUM_W-1] ? SUM_W'(-sum_m) : SUM_W'(sum_m);
  // 3*old + 2*cur + 2, divided by five
  assign filt_dvd = DN_W'({filt_m, 1'b0}) + DN_W'(filt_m) + DN_W'({cur_m, 1'b0}) + 32'd2;

  // detector: saturates to one once the scaled square reaches 2^48
  assign big   = |mul_prod[MP_W-1:48];
  assign dsq16 = mul_prod[47:32];
  assign sq16  = mul_prod[31:16];

  // overload step value and level dividend 9*old + o + 5, biased positive
  assign ratio = mul_prod[46:16];
  assign o_c   = (ratio > 31'd8454143) ? 32'sd8388607
                                       : $signed({1'b0, ratio}) - 32'sd65536;
  assign lvl_s = 32'(lvl_m);
  assign t_c   = (lvl_s <<< 3) + lvl_s + o_c + 32'sd5 + $signed(odc_pkg::LVL_OFS);

  assign lvl_new = LVL_W'(div_q - odc_pkg::LVL_BIAS);
  assign ovl     = lvl_new > $signed({8'h00, thr_r});
  assign cnt_new = ovl ? ((cnt_m == '1) ? cnt_m : cnt_m + 1'b1) : '0;

  assign out_go  = !out_valid_r || !out_stall;
  assign ring_wr = (state_r == odc_pkg::ST_LVL) && div_done && mot_r;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      odc_pkg::ST_IDLE: if (in_valid) state_nxt = odc_pkg::ST_FILT;
      odc_pkg::ST_FILT: state_nxt = odc_pkg::ST_DIVF;
      odc_pkg::ST_DIVF: if (div_done) state_nxt = odc_pkg::ST_MEAN;
      odc_pkg::ST_MEAN: if (div_done) state_nxt = odc_pkg::ST_SQ;
      odc_pkg::ST_SQ:   if (mul_done) state_nxt = odc_pkg::ST_DSQ;
      odc_pkg::ST_DSQ: begin
        if (mul_done) state_nxt = big ? odc_pkg::ST_ATT : odc_pkg::ST_POW;
      end
      odc_pkg::ST_POW: begin
        if (mul_done && pcnt_r == odc_pkg::POW_LAST) state_nxt = odc_pkg::ST_ATT;
      end
      odc_pkg::ST_ATT:  if (mul_done) state_nxt = odc_pkg::ST_RAT;
      odc_pkg::ST_RAT:  if (mul_done) state_nxt = odc_pkg::ST_LVL;
      odc_pkg::ST_LVL: begin
        if (div_done) state_nxt = mot_r ? odc_pkg::ST_DONE : odc_pkg::ST_FILT;
      end
      odc_pkg::ST_DONE: if (out_go) state_nxt = odc_pkg::ST_IDLE;
      default: state_nxt = odc_pkg::ST_IDLE;
    endcase
  end

  // ---- unit requests ----
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state_r)
      odc_pkg::ST_FILT: begin
        div_req.start = 1'b1;
        div_req.n     = filt_dvd;
        div_req.d     = odc_pkg::DIV_FILT;
      end
      odc_pkg::ST_DIVF: begin
        div_req.start = div_done;
        div_req.n     = DN_W'(abs_sum);
        div_req.d     = DD_W'(RING_DEPTH);
      end
      odc_pkg::ST_MEAN: begin
        mul_req.start = div_done;
        mul_req.a     = MA_W'(div_q[CUR_W-1:0]);
        mul_req.b     = MB_W'(div_q[CUR_W-1:0]);
      end
      odc_pkg::ST_SQ: begin
        mul_req.start = mul_done;
        mul_req.a     = mul_prod[MA_W-1:0];
        mul_req.b     = dsq_m;
      end
      odc_pkg::ST_DSQ: begin
        mul_req.start = mul_done;
        if (big) begin
          mul_req.a = MA_W'(filt_m);
          mul_req.b = '0;
        end else begin
          mul_req.a = MA_W'(dsq16);
          mul_req.b = MB_W'(dsq16);
        end
      end
      odc_pkg::ST_POW: begin
        mul_req.start = mul_done;
        if (pcnt_r == odc_pkg::POW_LAST) begin
          mul_req.a = MA_W'(filt_m);
          mul_req.b = MB_W'(odc_pkg::DET_ONE - {1'b0, sq16});
        end else begin
          mul_req.a = MA_W'(sq16);
          mul_req.b = MB_W'(sq16);
        end
      end
      odc_pkg::ST_ATT: begin
        mul_req.start = mul_done;
        mul_req.a     = MA_W'(mul_prod[38:16]);
        mul_req.b     = MB_W'(avg_m);
      end
      odc_pkg::ST_RAT: begin
        div_req.start = mul_done;
        div_req.n     = DN_W'(t_c);
        div_req.d     = odc_pkg::DIV_LVL;
      end
      default: begin
        mul_req = '0;
        div_req = '0;
      end
    endcase
  end

  // ---- control and state registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= odc_pkg::ST_IDLE;
      mot_r       <= 1'b0;
      pcnt_r      <= '0;
      ptr_r       <= '0;
      filt_r[0]   <= '0;
      filt_r[1]   <= '0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      lvl_r[0]    <= '0;
      lvl_r[1]    <= '0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        odc_pkg::ST_IDLE: mot_r <= 1'b0;
        odc_pkg::ST_FILT: sum_r[mot_r] <= sum_c;
        odc_pkg::ST_DIVF: if (div_done) filt_r[mot_r] <= div_q[CUR_W-1:0];
        odc_pkg::ST_DSQ:  if (mul_done) pcnt_r <= '0;
        odc_pkg::ST_POW:  if (mul_done) pcnt_r <= pcnt_r + 1'b1;
        odc_pkg::ST_LVL: begin
          if (div_done) begin
            lvl_r[mot_r] <= lvl_new;
            cnt_r[mot_r] <= cnt_new;
            mot_r        <= 1'b1;
            if (mot_r) begin
              ptr_r <= (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
            end
          end
        end
        default: mot_r <= mot_r;
      endcase
      if (state_r == odc_pkg::ST_DONE && out_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (state_r == odc_pkg::ST_IDLE && in_valid) begin
      cur_r[0] <= odc_pkg::sample_to_cur(in_sample_left);
      cur_r[1] <= odc_pkg::sample_to_cur(in_sample_right);
    end
    if (state_r == odc_pkg::ST_FILT) diff_r[mot_r] <= diff_c;
    if (state_r == odc_pkg::ST_DSQ && mul_done) begin
      det_r[mot_r] <= big ? odc_pkg::DET_ONE : {1'b0, dsq16};
    end
    if (state_r == odc_pkg::ST_POW && mul_done) det_r[mot_r] <= {1'b0, sq16};
    if (state_r == odc_pkg::ST_DONE && out_go) begin
      abort_r <= (cnt_r[0] > limit_r) || (cnt_r[1] > limit_r);
      ofl_r   <= filt_r[0];
      ofr_r   <= filt_r[1];
      odl_r   <= det_r[0][DET_W-1] ? 16'hFFFF : det_r[0][15:0];
      odr_r   <= det_r[1][DET_W-1] ? 16'hFFFF : det_r[1][15:0];
      ocl_r   <= cnt_r[0];
      ocr_r   <= cnt_r[1];
    end
  end

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsq_l_r <= 32'd65536;
      dsq_r_r <= 32'd65536;
      avg_l_r <= 24'd65536;
      avg_r_r <= 24'd65536;
      thr_r   <= 16'd6554;
      limit_r <= 8'd10;
    end else if (cfg_valid) begin
      case (odc_pkg::cfg_reg_t'(cfg_index))
        odc_pkg::REG_DSQ_L: dsq_l_r <= cfg_data;
        odc_pkg::REG_DSQ_R: dsq_r_r <= cfg_data;
        odc_pkg::REG_AVG_L: avg_l_r <= cfg_data[23:0];
        odc_pkg::REG_AVG_R: avg_r_r <= cfg_data[23:0];
        odc_pkg::REG_THR:   thr_r   <= cfg_data[15:0];
        odc_pkg::REG_LIMIT: limit_r <= cfg_data[7:0];
        default:            limit_r <= limit_r;
      endcase
    end
  end

  assign in_stall             = (state_r != odc_pkg::ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_abort            = abort_r;
  assign out_filtered_left    = ofl_r;
  assign out_filtered_right   = ofr_r;
  assign out_detector_left    = odl_r;
  assign out_detector_right   = odr_r;
  assign out_over_count_left  = ocl_r;
  assign out_over_count_right = ocr_r;
endmodule
`default_nettype wire

### design/odc_checker.sv
// Port-level checker for the motor overcurrent detector, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module odc_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [15:0] in_sample_left,
  input wire logic [15:0] in_sample_right,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_abort,
  input wire logic [22:0] out_filtered_left,
  input wire logic [22:0] out_filtered_right,
  input wire logic [15:0] out_detector_left,
  input wire logic [15:0] out_detector_right,
  input wire logic [7:0]  out_over_count_left,
  input wire logic [7:0]  out_over_count_right,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [2:0]  cfg_index,
  input wire logic [31:0] cfg_data
);
  // a stalled result beat stays valid and keeps its left filtered value and right overload count
  `ODC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_filtered_left) && $stable(out_over_count_right))
  // one item at a time: the cycle after an accepted beat the input is stalled
  `ODC_ASSERT_NXT(a_in_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  // abort needs a nonzero overload count on some motor
  `ODC_ASSERT_IMP(a_abort_cnt, clk, rst_n, out_valid && out_abort, out_over_count_left != 8'd0 || out_over_count_right != 8'd0)
endmodule

bind motor_overcurrent_detector odc_port_checker u_odc_checker (.*);
`default_nettype wire
